[rtl/core/bark_band_specific_loudness_unit_defines.svh]
// ----------------------------------------------------------------------------
// Bark band specific loudness: assertion macros
// Shared property wrappers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef BARK_BAND_SPECIFIC_LOUDNESS_UNIT_DEFINES_SVH
`define BARK_BAND_SPECIFIC_LOUDNESS_UNIT_DEFINES_SVH

// same-cycle implication
`define BBSL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BBSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/bbsl_pkg.sv]
// ----------------------------------------------------------------------------
// Bark band specific loudness package
// Transaction types, queue entry type and the exp2 root table.
// ----------------------------------------------------------------------------
package bbsl_pkg;

  localparam int LIMIT_W = 11;
  localparam int SUM_W   = 42;
  localparam int BAND_W  = 5;
  localparam int LOUD_W  = 24;
  localparam logic [13:0] POW_Q16 = 14'd15073;

  localparam logic KIND_LIMIT = 1'b0;
  localparam logic KIND_BIN   = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [4:0]         limit_index;
    logic [LIMIT_W-1:0] limit_bin;
    logic [31:0]        bin_value;
    logic               last_bin;
  } item_t;

  typedef struct packed {
    logic [BAND_W-1:0] band_index;
    logic [LOUD_W-1:0] loudness;
    logic              last_band;
  } result_t;

  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic [SUM_W-1:0]  sum;
    logic              last_band;
  } entry_t;

  typedef logic [31:0] exp_tab_t [0:16];

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = x;
    r = '0;
    b = 64'd1 << 62;
    for (int n = 0; n < 32; n++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic exp_tab_t gen_exp_tab();
    exp_tab_t t;
    logic [63:0] w;
    t[0] = '0;
    w = isqrt64(64'd1 << 61);
    t[1] = w[31:0];
    for (int k = 1; k < 16; k++) begin
      w = isqrt64({32'd0, t[k]} << 30);
      t[k+1] = w[31:0];
    end
    return t;
  endfunction

  // 2^(2^-k) in Q2.30 for k >= 1; entry 0 is zero
  localparam exp_tab_t EXP_TAB = gen_exp_tab();

endpackage

[rtl/core/bark_band_specific_loudness_unit.sv]
// ----------------------------------------------------------------------------
// Bark band specific loudness unit
// Sums spectrum bins into Bark bands and reports each band's sum^0.23.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_stall/item): kind 0 loads one band limit,
//   kind 1 delivers one spectrum bin; last_bin ends the frame.
//   result channel (result_valid/result_stall/result): one transaction per
//   closed band, band_index, loudness in unsigned Q10.14, last_band.
// Flow: limit writes are taken back to back; after a bin the front end holds
//   off items while it closes the bands that bin ends, and after the last bin
//   of a frame while it flushes the open bands; it also waits while the
//   two-entry band queue is full. The iterative power unit takes one band at
//   a time: a band with a nonzero sum passes load, 6 normalize, 16 log2
//   squarings, scale, 16 exp2 root steps, finish and output; an empty band passes load and output.
// Reset clears the bin counter, open band, band sum, queue and output; the
//   limit table keeps its content and must be loaded before use.
// When result_stall is high the result register holds, the queue fills and
//   then item_stall rises.
// ----------------------------------------------------------------------------
module bark_band_specific_loudness_unit #(
  parameter int BANDS    = 24,
  parameter int MAX_BINS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  bbsl_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output bbsl_pkg::result_t result
);
  import bbsl_pkg::*;

  entry_t push_entry, pop_entry;
  logic   push, pop, full, empty;

  bbsl_front #(.BANDS(BANDS), .MAX_BINS(MAX_BINS)) u_front (
    .clk, .rst, .item_valid, .item_stall, .item,
    .push, .push_entry, .full
  );

  bbsl_queue u_queue (
    .clk, .rst, .push, .push_entry, .full, .pop, .pop_entry, .empty
  );

  bbsl_back u_back (
    .clk, .rst, .empty, .pop, .entry(pop_entry),
    .result_valid, .result_stall, .result
  );

endmodule

[rtl/core/bbsl_front.sv]
// ----------------------------------------------------------------------------
// Bark band specific loudness: front end
// Holds the band limit table, counts bins, accumulates and closes bands.
// ----------------------------------------------------------------------------
module bbsl_front #(
  parameter int BANDS    = 24,
  parameter int MAX_BINS = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  bbsl_pkg::item_t item,
  output logic            push,
  output bbsl_pkg::entry_t push_entry,
  input  logic            full
);
  import bbsl_pkg::*;

  localparam int DEPTH = BANDS + 1;
  localparam int IDXW  = $clog2(BANDS + 1);
  localparam int CNTW  = $clog2(MAX_BINS + 1);
  localparam int CMPW  = (CNTW > LIMIT_W) ? CNTW : LIMIT_W;
  localparam logic [IDXW-1:0] BANDS_I = IDXW'(BANDS);
  localparam logic [CNTW-1:0] MAX_C   = CNTW'(MAX_BINS);

  typedef enum logic [1:0] {S_IDLE, S_HI, S_FLUSH} state_t;

  state_t             state, state_next;
  logic [IDXW-1:0]    cb, cb_next;
  logic [CNTW-1:0]    counter, counter_next;
  logic [SUM_W-1:0]   sum, sum_next;
  logic [CNTW-1:0]    k;
  logic [31:0]        val;
  logic               last;
  logic [LIMIT_W-1:0] limits [DEPTH];
  logic [LIMIT_W-1:0] rd_hi, rd_lo;
  logic [IDXW-1:0]    sel_hi, sel_lo;
  logic [SUM_W:0]     s_add;
  logic               open_band, accept;

  assign accept     = (state == S_IDLE) && item_valid;
  assign item_stall = (state != S_IDLE);
  assign open_band  = (cb < BANDS_I);
  assign s_add      = {1'b0, sum} + (SUM_W+1)'(val);

  always_comb begin
    state_next   = state;
    cb_next      = cb;
    sum_next     = sum;
    counter_next = counter;
    push         = 1'b0;
    push_entry.band      = BAND_W'(cb);
    push_entry.sum       = sum;
    push_entry.last_band = (cb == BANDS_I - 1'b1);
    unique case (state)
      S_IDLE: begin
        if (accept && item.kind == KIND_BIN) state_next = S_HI;
      end
      S_HI: begin
        if (open_band && CMPW'(k) >= CMPW'(rd_hi)) begin
          if (!full) begin
            push     = 1'b1;
            sum_next = '0;
            cb_next  = cb + 1'b1;
          end
        end else if (last) begin
          state_next = S_FLUSH;
        end else begin
          if (open_band && CMPW'(k) >= CMPW'(rd_lo))
            sum_next = s_add[SUM_W] ? '1 : s_add[SUM_W-1:0];
          if (counter < MAX_C) counter_next = counter + 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (open_band) begin
          if (!full) begin
            push     = 1'b1;
            sum_next = '0;
            cb_next  = cb + 1'b1;
          end
        end else begin
          cb_next      = '0;
          sum_next     = '0;
          counter_next = '0;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign sel_lo = cb_next;
  assign sel_hi = (cb_next == BANDS_I) ? BANDS_I : cb_next + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cb      <= '0;
      counter <= '0;
      sum     <= '0;
    end else begin
      state   <= state_next;
      cb      <= cb_next;
      counter <= counter_next;
      sum     <= sum_next;
    end
    if (accept) begin
      k    <= counter;
      val  <= item.bin_value;
      last <= item.last_bin;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.kind == KIND_LIMIT && {1'b0, item.limit_index} <= 6'(BANDS))
      limits[IDXW'(item.limit_index)] <= item.limit_bin;
    rd_hi <= limits[sel_hi];
    rd_lo <= limits[sel_lo];
  end

endmodule

[rtl/core/bbsl_queue.sv]
// ----------------------------------------------------------------------------
// Bark band specific loudness: band queue
// Two-entry queue of closed bands between front and back end.
// ----------------------------------------------------------------------------
module bbsl_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bbsl_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output bbsl_pkg::entry_t pop_entry,
  output logic             empty
);
  import bbsl_pkg::*;

  entry_t     slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign empty     = (count == 2'd0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) slots[wr_ptr] <= push_entry;
  end

endmodule

[rtl/core/bbsl_back.sv]
// ----------------------------------------------------------------------------
// Bark band specific loudness: back end
// Iterative sum^0.23 via normalize, log2 by squaring, scale, exp2 by roots.
// ----------------------------------------------------------------------------
module bbsl_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  output logic              pop,
  input  bbsl_pkg::entry_t  entry,
  output logic              result_valid,
  input  logic              result_stall,
  output bbsl_pkg::result_t result
);
  import bbsl_pkg::*;

  typedef enum logic [2:0] {B_IDLE, B_NORM, B_LOG, B_POW, B_EXP, B_FIN, B_OUT} state_t;

  localparam logic [LOUD_W-1:0] OUT_MAX = '1;

  state_t            state;
  logic [3:0]        step;
  logic [SUM_W-1:0]  m, m_sh;
  logic [5:0]        e, e_sh, sh;
  logic [31:0]       logm, r;
  logic [21:0]       lg;
  logic [19:0]       pw;
  logic [BAND_W-1:0] band;
  logic              lastb;
  logic [LOUD_W-1:0] loud;
  logic [63:0]       sq, ex;
  logic [35:0]       pp;
  logic [47:0]       vs;

  assign pop = (state == B_IDLE) && !empty;

  always_comb begin
    sh   = 6'd32 >> step;
    m_sh = m;
    e_sh = e;
    if ((m >> (6'(SUM_W) - sh)) == '0) begin
      m_sh = m << sh;
      e_sh = e - sh;
    end
  end

  assign sq = 64'(logm) * 64'(logm);
  assign ex = 64'(r) * 64'(EXP_TAB[5'(step) + 5'd1]) + (64'd1 << 29);
  assign pp = 36'(lg) * 36'(POW_Q16);
  assign vs = 48'(r) << pw[19:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != B_OUT) result_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (!empty) begin
            band  <= entry.band;
            lastb <= entry.last_band;
            m     <= entry.sum;
            e     <= 6'(SUM_W - 1);
            step  <= '0;
            loud  <= '0;
            state <= (entry.sum == '0) ? B_OUT : B_NORM;
          end
        end
        B_NORM: begin
          m    <= m_sh;
          e    <= e_sh;
          step <= step + 1'b1;
          if (step == 4'd5) begin
            logm  <= m_sh[SUM_W-1 -: 32];
            lg    <= {e_sh, 16'd0};
            step  <= '0;
            state <= B_LOG;
          end
        end
        B_LOG: begin
          if (sq[63]) begin
            lg[4'd15 - step] <= 1'b1;
            logm <= sq[63:32];
          end else begin
            logm <= sq[62:31];
          end
          step <= step + 1'b1;
          if (step == 4'd15) state <= B_POW;
        end
        B_POW: begin
          pw    <= pp[35:16];
          r     <= 32'd1 << 30;
          step  <= '0;
          state <= B_EXP;
        end
        B_EXP: begin
          if (pw[4'd15 - step]) r <= ex[61:30];
          step <= step + 1'b1;
          if (step == 4'd15) state <= B_FIN;
        end
        B_FIN: begin
          if (pw[19:16] >= 4'd10 || vs[47:16] > 32'(OUT_MAX)) loud <= OUT_MAX;
          else loud <= vs[16 +: LOUD_W];
          state <= B_OUT;
        end
        B_OUT: begin
          if (!result_valid || !result_stall) begin
            result_valid      <= 1'b1;
            result.band_index <= band;
            result.loudness   <= loud;
            result.last_band  <= lastb;
            state             <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/bbsl_checker.sv]
// ----------------------------------------------------------------------------
// Bark band specific loudness: port checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "bark_band_specific_loudness_unit_defines.svh"

module bbsl_checker #(
  parameter int BANDS = 24
) (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input bbsl_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_stall,
  input bbsl_pkg::result_t result
);
  import bbsl_pkg::*;

  `BBSL_ASSERT_NEXT(a_res_hold, result_valid && result_stall, result_valid, "result dropped while stalled")
  `BBSL_ASSERT_NEXT(a_res_stable, result_valid && result_stall, $stable(result), "stalled result changed")
  `BBSL_ASSERT_NEXT(a_bin_busy, item_valid && !item_stall && item.kind == KIND_BIN, item_stall, "bin transaction not held off")
  `BBSL_ASSERT_NOW(a_last_band, result_valid && result.last_band, result.band_index == BAND_W'(BANDS - 1), "last_band on wrong band")

endmodule

bind bark_band_specific_loudness_unit bbsl_checker #(.BANDS(BANDS)) u_bbsl_checker (.*);
